FILE: hw/rtl/kernel_ratio_frequency_estimator_macros.svh
// Assertion macros shared by the estimator RTL.
`ifndef KERNEL_RATIO_FREQUENCY_ESTIMATOR_MACROS_SVH
`define KERNEL_RATIO_FREQUENCY_ESTIMATOR_MACROS_SVH
`ifndef SYNTHESIS
`define KRFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define KRFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KRFE_ASSERT(lbl, prop)
`define KRFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/krfe_pkg.sv
// Types and constants of the kernel ratio frequency estimator.
package krfe_pkg;

  localparam int WIN_MAX_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS       = 24;
  localparam int ACC_BITS        = 64;
  localparam int EST_BITS        = 32;
  localparam int WLEN_BITS       = 9;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic [WLEN_BITS-1:0]     WIN_LEN_RESET = 9'd256;
  localparam logic [CFG_DATA_BITS-1:0] MIN_DEN_RESET = 32'd1;

  localparam logic CFG_WINDOW_LEN = 1'b0;
  localparam logic CFG_MIN_DEN    = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_SQRT
  } phase_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic sat;
  } root_req_t;

endpackage

FILE: hw/rtl/kernel_ratio_frequency_estimator.sv
// Kernel ratio frequency estimator: sample window, kernel memories and sequencer.
//
// Input channel (in_valid/in_ready) carries either a kernel tap load (in_cmd = 1),
// which is written in the transfer cycle and returns nothing, or a new sample
// (in_cmd = 0), which returns exactly one result on the out_ channel.
// While the window fills, the result of a sample carries the held estimate
// with out_updated low.
// Once full, the pass over the window reads one tap per cycle through the memory
// read port and the dual MAC, then drains the pipeline. When an update is due,
// the shared subtractor runs 64 division steps and 32 square root steps and then
// hands over the root; when the ratio saturates, the division is skipped.
// in_ready is low while a sample is in work and rises in the cycle its result is
// placed in the output register, so the next item is taken while it waits.
// A stalled receiver holds only the result; a second sample then waits for
// the register to empty before its result is placed.
// Reset clears the fill count, the held estimate and the registers to their
// reset values; kernel taps and window samples are undefined until written.
// cfg_we writes register cfg_index (0 window_len, 1 min_denominator) at once.
`include "kernel_ratio_frequency_estimator_macros.svh"
module kernel_ratio_frequency_estimator #(
  parameter int WIN_MAX     = krfe_pkg::WIN_MAX_DEF,
  parameter int SAMPLE_BITS = krfe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_cmd,
  input  logic [7:0]                              in_index,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample,
  input  logic signed [krfe_pkg::COEF_BITS-1:0]   in_coef_product,
  input  logic signed [krfe_pkg::COEF_BITS-1:0]   in_coef_gauss,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [krfe_pkg::EST_BITS-1:0]           out_estimate,
  output logic                                    out_updated,
  output logic                                    out_window_full,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [krfe_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  localparam int AW = $clog2(WIN_MAX);
  localparam int NW = $clog2(WIN_MAX + 1);
  localparam int CW = krfe_pkg::COEF_BITS;
  localparam int W  = krfe_pkg::ACC_BITS;

  logic signed [SAMPLE_BITS-1:0] win_mem [WIN_MAX];
  logic signed [CW-1:0]          kp_mem  [WIN_MAX];
  logic signed [CW-1:0]          kg_mem  [WIN_MAX];

  krfe_pkg::state_t state_r, state_nxt;
  logic [krfe_pkg::WLEN_BITS-1:0]     wlen_r;
  logic [krfe_pkg::CFG_DATA_BITS-1:0] min_den_r;
  logic [NW-1:0] fill_r, fill_nxt, n_eff;
  logic [AW-1:0] s_r, s_nxt;
  logic [AW-1:0] rd_addr_r;
  logic          rd_v_r, rd_last_r, issue;
  logic signed [SAMPLE_BITS-1:0] z_r, win_rd_r, x_cur;
  logic signed [CW-1:0]          kp_rd_r, kg_rd_r;
  logic [krfe_pkg::EST_BITS-1:0] held_r, held_nxt;
  logic          res_upd_r, res_upd_nxt, res_full_r, res_full_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [krfe_pkg::EST_BITS-1:0] out_est_r;
  logic          out_upd_r, out_full_r;
  logic          in_xfer, is_load, is_sample, fill_mode;
  logic [W-1:0]  sum1, sum2, mag1, mag2;
  logic          mac_busy, root_done, do_update, sat;
  logic [krfe_pkg::EST_BITS-1:0] root_val;
  krfe_pkg::mac_ctl_t  mac_ctl;
  krfe_pkg::root_req_t root_req;

  // Effective window length, clamped to [2, WIN_MAX].
  always_comb begin
    if (wlen_r < 9'd2) n_eff = NW'(2);
    else if (32'(wlen_r) > 32'(WIN_MAX)) n_eff = NW'(WIN_MAX);
    else n_eff = NW'(wlen_r);
  end

  assign in_ready  = (state_r == krfe_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_load   = in_xfer && (in_cmd == krfe_pkg::CMD_LOAD);
  assign is_sample = in_xfer && (in_cmd == krfe_pkg::CMD_SAMPLE);
  assign fill_mode = fill_r < n_eff;
  assign issue     = (state_r == krfe_pkg::ST_MAC);

  assign mag1 = sum1[W-1] ? W'(0) - sum1 : sum1;
  assign mag2 = sum2[W-1] ? W'(0) - sum2 : sum2;
  assign do_update = (sum1 != '0) && (sum2 != '0) && (sum1[W-1] ^ sum2[W-1]) &&
                     (mag2 > W'(min_den_r));
  assign sat = {32'b0, mag1[W-1:32]} >= mag2;

  assign x_cur = rd_last_r ? z_r : win_rd_r;

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    fill_nxt      = fill_r;
    held_nxt      = held_r;
    res_upd_nxt   = res_upd_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mac_ctl       = '{clear: 1'b0, en: rd_v_r};
    root_req      = '{start: 1'b0, sat: sat};
    unique case (state_r)
      krfe_pkg::ST_IDLE: begin
        if (is_sample) begin
          if (fill_mode) begin
            fill_nxt     = fill_r + NW'(1);
            res_upd_nxt  = 1'b0;
            res_full_nxt = (fill_r + NW'(1)) >= n_eff;
            state_nxt    = krfe_pkg::ST_DONE;
          end else begin
            s_nxt         = '0;
            mac_ctl.clear = 1'b1;
            state_nxt     = krfe_pkg::ST_MAC;
          end
        end
      end
      krfe_pkg::ST_MAC: begin
        s_nxt = s_r + AW'(1);
        if (NW'(s_r) == n_eff - NW'(1)) state_nxt = krfe_pkg::ST_DRAIN;
      end
      krfe_pkg::ST_DRAIN: begin
        if (!rd_v_r && !mac_busy) begin
          res_full_nxt = 1'b1;
          if (do_update) begin
            root_req.start = 1'b1;
            state_nxt      = krfe_pkg::ST_ROOT;
          end else begin
            res_upd_nxt = 1'b0;
            state_nxt   = krfe_pkg::ST_DONE;
          end
        end
      end
      krfe_pkg::ST_ROOT: begin
        if (root_done) begin
          held_nxt    = root_val;
          res_upd_nxt = 1'b1;
          state_nxt   = krfe_pkg::ST_DONE;
        end
      end
      krfe_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = krfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = krfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krfe_pkg::ST_IDLE;
      fill_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      wlen_r      <= krfe_pkg::WIN_LEN_RESET;
      min_den_r   <= krfe_pkg::MIN_DEN_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= issue;
      if (cfg_we) begin
        unique case (cfg_index)
          krfe_pkg::CFG_WINDOW_LEN: wlen_r    <= cfg_wdata[krfe_pkg::WLEN_BITS-1:0];
          krfe_pkg::CFG_MIN_DEN:    min_den_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    res_upd_r  <= res_upd_nxt;
    res_full_r <= res_full_nxt;
    rd_addr_r  <= s_r;
    rd_last_r  <= (NW'(s_r) == n_eff - NW'(1));
    if (in_xfer) z_r <= in_sample;
    if (state_r == krfe_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_est_r  <= held_r;
      out_upd_r  <= res_upd_r;
      out_full_r <= res_full_r;
    end
  end

  // Window memory: appended during fill, shifted down by one during the pass.
  always_ff @(posedge clk) begin
    win_rd_r <= win_mem[s_r + AW'(1)];
    if (is_sample && fill_mode) win_mem[AW'(fill_r)] <= in_sample;
    else if (rd_v_r) win_mem[rd_addr_r] <= x_cur;
  end

  always_ff @(posedge clk) begin
    kp_rd_r <= kp_mem[s_r];
    kg_rd_r <= kg_mem[s_r];
    if (is_load && (32'(in_index) < 32'(WIN_MAX))) begin
      kp_mem[AW'(32'(in_index))] <= in_coef_product;
      kg_mem[AW'(32'(in_index))] <= in_coef_gauss;
    end
  end

  krfe_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (x_cur),
    .kp    (kp_rd_r),
    .kg    (kg_rd_r),
    .sum1  (sum1),
    .sum2  (sum2),
    .busy  (mac_busy)
  );

  krfe_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .num   (mag1),
    .den   (mag2),
    .done  (root_done),
    .root  (root_val)
  );

  assign out_valid       = out_valid_r;
  assign out_estimate    = out_est_r;
  assign out_updated     = out_upd_r;
  assign out_window_full = out_full_r;

  `KRFE_ASSERT(a_upd_full, out_valid_r && out_upd_r |-> out_full_r)
  `KRFE_ASSERT(a_done_in_root, root_done |-> state_r == krfe_pkg::ST_ROOT)
  `KRFE_ASSERT_NEXT(a_sample_busy, is_sample, state_r != krfe_pkg::ST_IDLE)

endmodule

FILE: hw/rtl/krfe_mac.sv
// Dual multiply-accumulate lane for the two kernel correlations.
module krfe_mac #(
  parameter int SAMPLE_BITS = krfe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  krfe_pkg::mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_BITS-1:0]        x,
  input  logic signed [krfe_pkg::COEF_BITS-1:0] kp,
  input  logic signed [krfe_pkg::COEF_BITS-1:0] kg,
  output logic [krfe_pkg::ACC_BITS-1:0]        sum1,
  output logic [krfe_pkg::ACC_BITS-1:0]        sum2,
  output logic                                 busy
);

  localparam int PW = SAMPLE_BITS + krfe_pkg::COEF_BITS;

  logic signed [PW-1:0] p1_r, p2_r;
  logic                 prod_v_r;
  logic [krfe_pkg::ACC_BITS-1:0] sum1_r, sum2_r;
  logic signed [krfe_pkg::ACC_BITS-1:0] e1, e2;

  assign e1 = krfe_pkg::ACC_BITS'(p1_r);
  assign e2 = krfe_pkg::ACC_BITS'(p2_r);

  always_ff @(posedge clk) begin
    p1_r <= x * kp;
    p2_r <= x * kg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      prod_v_r <= 1'b0;
      sum1_r   <= '0;
      sum2_r   <= '0;
    end else begin
      prod_v_r <= ctl.en;
      if (prod_v_r) begin
        sum1_r <= sum1_r + e1;
        sum2_r <= sum2_r + e2;
      end
    end
  end

  assign sum1 = sum1_r;
  assign sum2 = sum2_r;
  assign busy = prod_v_r;

endmodule

FILE: hw/rtl/krfe_root.sv
// Bit-serial Q32.32 ratio divider followed by integer square root on one subtractor.
module krfe_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  krfe_pkg::root_req_t           req,
  input  logic [krfe_pkg::ACC_BITS-1:0] num,
  input  logic [krfe_pkg::ACC_BITS-1:0] den,
  output logic                          done,
  output logic [krfe_pkg::EST_BITS-1:0] root
);

  localparam int W = krfe_pkg::ACC_BITS;

  krfe_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [W-1:0] rem_r, rem_nxt, dvd_r, dvd_nxt, q_r, q_nxt, den_r, den_nxt;
  logic [W-1:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [W:0]   a_sel, b_sel;
  logic [W+1:0] diff;
  logic         ge;
  logic         done_nxt;

  // The one subtractor serves both the division and the square root steps.
  always_comb begin
    if (phase_r == krfe_pkg::PH_DIV) begin
      a_sel = {rem_r, dvd_r[W-1]};
      b_sel = {1'b0, den_r};
    end else begin
      a_sel = {1'b0, v_r};
      b_sel = {1'b0, res_r + bit_r};
    end
    diff = {1'b0, a_sel} - {1'b0, b_sel};
    ge   = !diff[W+1];
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    q_nxt     = q_r;
    den_nxt   = den_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      krfe_pkg::PH_IDLE: begin
        if (req.start) begin
          den_nxt = den;
          cnt_nxt = '0;
          res_nxt = '0;
          bit_nxt = W'(1) << (W - 2);
          q_nxt   = '0;
          if (req.sat) begin
            v_nxt     = '1;
            phase_nxt = krfe_pkg::PH_SQRT;
          end else begin
            rem_nxt   = {32'b0, num[W-1:32]};
            dvd_nxt   = {num[31:0], 32'b0};
            phase_nxt = krfe_pkg::PH_DIV;
          end
        end
      end
      krfe_pkg::PH_DIV: begin
        rem_nxt = ge ? diff[W-1:0] : a_sel[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        q_nxt   = {q_r[W-2:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          v_nxt     = q_nxt;
          cnt_nxt   = '0;
          phase_nxt = krfe_pkg::PH_SQRT;
        end
      end
      krfe_pkg::PH_SQRT: begin
        if (ge) begin
          v_nxt   = diff[W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          done_nxt  = 1'b1;
          phase_nxt = krfe_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = krfe_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= krfe_pkg::PH_IDLE;
      cnt_r   <= '0;
      done    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root = res_r[krfe_pkg::EST_BITS-1:0];

endmodule
